>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define LFU_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lfu assertion failed");

// consequence of a condition in the following cycle, checked outside reset
`define LFU_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lfu assertion failed");

`endif

>>> rtl/core/lfu_pkg.sv
// shared types and constants of the lfu frame replacement unit
package lfu_pkg;

	localparam int CAND_W        = 7;
	localparam int TIME_W        = 16;
	localparam int SLOT_W        = 5;
	localparam int STATUS_W      = 2;
	localparam int FRAMES_USED_W = 6;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [FRAMES_USED_W-1:0] FRAMES_USED_RESET = 6'd20;
	localparam logic [TIME_W-1:0]        TIME_MAX          = 16'hFFFF;

	// register index taken from paddr[2]
	localparam logic REG_FRAMES_USED = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED   = 2'd0,
		ST_SHOWN    = 2'd1,
		ST_REPLACED = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	// control of the shared minimum compare unit
	typedef struct packed {
		logic load;
		logic first;
	} scan_ctl_t;

endpackage

>>> rtl/core/lfu_ram.sv
// generic simple dual-port ram with registered read
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/lfu_scan_unit.sv
// shared compare unit: tracks the frame with fewest votes, oldest placement
module lfu_scan_unit #(
	parameter int IDX_W      = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  lfu_pkg::scan_ctl_t            ctl,
	input  logic [IDX_W-1:0]              idx,
	input  logic [lfu_pkg::CAND_W-1:0]    cand,
	input  logic [lfu_pkg::TIME_W-1:0]    stamp,
	input  logic [COUNT_BITS-1:0]         count,
	output logic [IDX_W-1:0]              best_idx,
	output logic [lfu_pkg::CAND_W-1:0]    best_cand
);

	logic [IDX_W-1:0]           best_idx_q;
	logic [lfu_pkg::CAND_W-1:0] best_cand_q;
	logic [lfu_pkg::TIME_W-1:0] best_time_q;
	logic [COUNT_BITS-1:0]      best_count_q;
	logic                       less;

	// strictly smaller, so equal entries keep the lower index
	assign less = (count < best_count_q) ||
		((count == best_count_q) && (stamp < best_time_q));

	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.first || less)) begin
			best_idx_q   <= idx;
			best_cand_q  <= cand;
			best_time_q  <= stamp;
			best_count_q <= count;
		end
	end

	assign best_idx  = best_idx_q;
	assign best_cand = best_cand_q;

endmodule

>>> rtl/core/lfu_frame_replacement_unit.sv
// lfu frame replacement unit: vote counting and least-frequently-used frame replacement
// one vote at a time; s_tready is high only while the sequencer is idle
// invalid id: result beat straight from idle through done; hit or fill of frame k: the match scan stops at frame k
// replacement with n active frames: a match scan and then a minimum scan over all n frames, one frame per cycle,
// over the single read port of the frame ram and the count ram
// after arst_n the vote count ram is cleared, entry by entry, before the first vote is taken
module lfu_frame_replacement_unit #(
	parameter int FRAMES     = 32,
	parameter int CANDIDATES = 128,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// stream in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [6:0] candidate
	// stream out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // [4:0] slot, [11:5] evicted
	output logic [lfu_pkg::STATUS_W-1:0]     m_tuser,  // [1:0] status
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lfu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lfu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int FA = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CA = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
	localparam int CW = lfu_pkg::CAND_W;
	localparam int TW = lfu_pkg::TIME_W;
	localparam int FW = CW + TW;
	// frames index the count store through this mask
	localparam logic [31:0] CMASK = 32'((CANDIDATES - 1) & 127);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_INC   = 8'b0000_0100,
		S_FIND  = 8'b0000_1000,
		S_MIN   = 8'b0001_0000,
		S_EVICT = 8'b0010_0000,
		S_DONE  = 8'b0100_0000,
		S_SPARE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration and global state
	logic [lfu_pkg::FRAMES_USED_W-1:0] frames_used_q;
	logic [TW-1:0]                     vote_index_q;
	logic [FRAMES-1:0]                 frame_valid_q;
	logic [CA-1:0]                     clr_idx_q;

	// item under work
	logic [CW-1:0] cand_q;
	logic [TW-1:0] now_q;
	logic [FA-1:0] last_q;
	logic [FA-1:0] last_d;

	// frame read pipeline: address, frame data, count data
	logic          rd_on_q;
	logic [FA-1:0] rd_idx_q;
	logic          p1_vld_q;
	logic [FA-1:0] p1_idx_q;
	logic          s2_vld_q;
	logic [FA-1:0] s2_idx_q;
	logic [CW-1:0] s2_cand_q;
	logic [TW-1:0] s2_time_q;

	// result waiting for the output register
	lfu_pkg::status_t     res_status_q;
	logic [FA-1:0]        res_slot_q;
	logic [CW-1:0]        res_evicted_q;

	// output register
	logic                          m_tvalid_q;
	logic [lfu_pkg::STATUS_W-1:0]  out_status_q;
	logic [lfu_pkg::SLOT_W-1:0]    out_slot_q;
	logic [CW-1:0]                 out_evicted_q;

	// ram ports
	logic                  frm_we;
	logic [FA-1:0]         frm_waddr;
	logic [FW-1:0]         frm_wdata;
	logic [FW-1:0]         frm_rdata;
	logic [CW-1:0]         frm_rd_cand;
	logic [TW-1:0]         frm_rd_time;
	logic                  cnt_we;
	logic [CA-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [CA-1:0]         cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [COUNT_BITS-1:0] cnt_inc;

	// shared compare unit
	lfu_pkg::scan_ctl_t scan_ctl;
	logic [FA-1:0]      best_idx;
	logic [CW-1:0]      best_cand;

	logic [CW-1:0] s_cand;
	logic          s_beat;
	logic          s_invalid;
	logic          hit_empty;
	logic          hit_match;
	logic          out_load;
	logic          cfg_wr;

	function automatic logic [CA-1:0] vote_addr(input logic [CW-1:0] c);
		return CA'(32'(c));
	endfunction

	function automatic logic [CA-1:0] frame_addr(input logic [CW-1:0] c);
		return CA'(32'(c) & CMASK);
	endfunction

	assign s_cand    = s_tdata[CW-1:0];
	assign s_tready  = (state_q == S_IDLE);
	assign s_beat    = s_tvalid && s_tready;
	assign s_invalid = (s_cand == '0) || (32'(s_cand) >= 32'(CANDIDATES));

	assign frm_rd_cand = frm_rdata[CW-1:0];
	assign frm_rd_time = frm_rdata[FW-1:CW];

	// the scan stops at the first empty frame or the frame already holding the vote
	assign hit_empty = p1_vld_q && !frame_valid_q[p1_idx_q];
	assign hit_match = p1_vld_q && frame_valid_q[p1_idx_q] && (frm_rd_cand == cand_q);

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// saturating increment of the voted candidate's count
	assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);

	// active frame count clamped to 1 .. FRAMES, kept as last index
	always_comb begin
		if (frames_used_q == '0) begin
			last_d = '0;
		end else if (32'(frames_used_q) > 32'(FRAMES)) begin
			last_d = FA'(FRAMES - 1);
		end else begin
			last_d = FA'(32'(frames_used_q) - 32'd1);
		end
	end

	// count ram: clearing pass, increment, eviction clear; reads for vote and min scan
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = vote_addr(cand_q);
		cnt_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
			end
			S_INC: begin
				cnt_we    = 1'b1;
				cnt_wdata = cnt_inc;
			end
			S_EVICT: begin
				cnt_we    = 1'b1;
				cnt_waddr = frame_addr(best_cand);
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
		// idle reads the offered vote so the count is ready on the next cycle
		if (state_q == S_MIN) begin
			cnt_raddr = frame_addr(frm_rd_cand);
		end else begin
			cnt_raddr = vote_addr(s_cand);
		end
	end

	// frame ram: placement into an empty frame, or replacement of the minimum
	always_comb begin
		frm_wdata = {now_q, cand_q};
		if (state_q == S_EVICT) begin
			frm_we    = 1'b1;
			frm_waddr = best_idx;
		end else begin
			frm_we    = (state_q == S_FIND) && hit_empty;
			frm_waddr = p1_idx_q;
		end
	end

	assign scan_ctl.load  = (state_q == S_MIN) && s2_vld_q;
	assign scan_ctl.first = (s2_idx_q == '0);

	lfu_ram #(
		.WIDTH (FW),
		.DEPTH (FRAMES)
	) u_frame_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.raddr (rd_idx_q),
		.rdata (frm_rdata)
	);

	lfu_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (CANDIDATES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	lfu_scan_unit #(
		.IDX_W      (FA),
		.COUNT_BITS (COUNT_BITS)
	) u_scan (
		.clk       (clk),
		.ctl       (scan_ctl),
		.idx       (s2_idx_q),
		.cand      (s2_cand_q),
		.stamp     (s2_time_q),
		.count     (cnt_rdata),
		.best_idx  (best_idx),
		.best_cand (best_cand)
	);

	// configuration register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == lfu_pkg::REG_FRAMES_USED) ?
		lfu_pkg::APB_DATA_W'(frames_used_q) : '0;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			frames_used_q <= lfu_pkg::FRAMES_USED_RESET;
			vote_index_q  <= '0;
			frame_valid_q <= '0;
			clr_idx_q     <= '0;
			rd_on_q       <= 1'b0;
			rd_idx_q      <= '0;
			p1_vld_q      <= 1'b0;
			s2_vld_q      <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == lfu_pkg::REG_FRAMES_USED)) begin
				frames_used_q <= pwdata[lfu_pkg::FRAMES_USED_W-1:0];
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + CA'(1);
					if (clr_idx_q == CA'(CANDIDATES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_beat) begin
						if (s_invalid) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_INC;
							if (vote_index_q != lfu_pkg::TIME_MAX) begin
								vote_index_q <= vote_index_q + TW'(1);
							end
						end
					end
				end
				S_INC: begin
					// count written back this cycle; start the match scan at frame 0
					state_q  <= S_FIND;
					rd_on_q  <= 1'b1;
					rd_idx_q <= '0;
					p1_vld_q <= 1'b0;
				end
				S_FIND: begin
					p1_vld_q <= rd_on_q;
					if (rd_on_q) begin
						if (rd_idx_q == last_q) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + FA'(1);
						end
					end
					if (hit_empty) begin
						frame_valid_q[p1_idx_q] <= 1'b1;
						state_q <= S_DONE;
					end else if (hit_match) begin
						state_q <= S_DONE;
					end else if (p1_vld_q && (p1_idx_q == last_q)) begin
						// all active frames full: restart for the minimum scan
						state_q  <= S_MIN;
						rd_on_q  <= 1'b1;
						rd_idx_q <= '0;
						p1_vld_q <= 1'b0;
						s2_vld_q <= 1'b0;
					end
				end
				S_MIN: begin
					p1_vld_q <= rd_on_q;
					s2_vld_q <= p1_vld_q;
					if (rd_on_q) begin
						if (rd_idx_q == last_q) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + FA'(1);
						end
					end
					if (s2_vld_q && (s2_idx_q == last_q)) begin
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_beat) begin
			cand_q        <= s_cand;
			now_q         <= vote_index_q;
			last_q        <= last_d;
			res_status_q  <= lfu_pkg::ST_INVALID;
			res_slot_q    <= '0;
			res_evicted_q <= '0;
		end
		p1_idx_q  <= rd_idx_q;
		s2_idx_q  <= p1_idx_q;
		s2_cand_q <= frm_rd_cand;
		s2_time_q <= frm_rd_time;
		if (state_q == S_FIND) begin
			if (hit_empty) begin
				res_status_q <= lfu_pkg::ST_PLACED;
				res_slot_q   <= p1_idx_q;
			end else if (hit_match) begin
				res_status_q <= lfu_pkg::ST_SHOWN;
				res_slot_q   <= p1_idx_q;
			end
		end
		if (state_q == S_EVICT) begin
			res_status_q  <= lfu_pkg::ST_REPLACED;
			res_slot_q    <= best_idx;
			res_evicted_q <= best_cand;
		end
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_slot_q    <= lfu_pkg::SLOT_W'(32'(res_slot_q));
			out_evicted_q <= res_evicted_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_evicted_q, out_slot_q};

endmodule

>>> rtl/core/lfu_chk.sv
// port-level checker for the lfu frame replacement unit, bound to the top level
`include "assert_macros.svh"

module lfu_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [15:0]                  m_tdata,
	input logic [lfu_pkg::STATUS_W-1:0] m_tuser
);

	// a stalled result beat holds its payload
	`LFU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one vote at a time: the input closes right after a beat
	`LFU_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// an invalid id reports no frame and no eviction
	`LFU_ASSERT(a_invalid_zero, clk, arst_n, !(m_tvalid && (m_tuser == lfu_pkg::ST_INVALID)) || (m_tdata[11:0] == 12'd0))

	// only a replacement names an evicted candidate
	`LFU_ASSERT(a_evict_only_replace, clk, arst_n, !(m_tvalid && (m_tuser != lfu_pkg::ST_REPLACED)) || (m_tdata[11:5] == 7'd0))

	// a replacement always removes a real candidate
	`LFU_ASSERT(a_replace_evicts, clk, arst_n, !(m_tvalid && (m_tuser == lfu_pkg::ST_REPLACED)) || (m_tdata[11:5] != 7'd0))

endmodule

bind lfu_frame_replacement_unit lfu_chk u_lfu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
